[sv/rkf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replay key filter package
// Store dimensions, the token that travels along the cell row, the store
// write command and the controller states.
// ----------------------------------------------------------------------------
package rkf_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int WORD_W      = 64;
  localparam int KEY_W       = 4 * WORD_W;
  localparam int SLOT_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

  typedef struct packed {
    logic             active;
    logic             hit;
    logic [CNT_W-1:0] left;
  } tok_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
  } wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

endpackage

[sv/rkf_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replay key filter store cell
// Holds one stored key, compares it with the key under test while the token
// passes and hands the token on to the next cell in the following cycle.
// ----------------------------------------------------------------------------
module rkf_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [rkf_pkg::KEY_W-1:0] key_i,
  input  logic                     we_i,
  input  rkf_pkg::tok_t            tok_i,
  output rkf_pkg::tok_t            tok_o
);

  logic [rkf_pkg::KEY_W-1:0] entry_q;
  rkf_pkg::tok_t             tok_d;
  rkf_pkg::tok_t             tok_q;
  logic                      live;

  assign live = (tok_i.left != '0);

  always_comb begin
    tok_d.active = tok_i.active;
    tok_d.hit    = tok_i.hit | (tok_i.active & live & (entry_q == key_i));
    tok_d.left   = live ? tok_i.left - 1'b1 : tok_i.left;
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      entry_q <= key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

[sv/rkf_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replay key filter controller
// Takes in a key, launches the token into the cell row, waits for it at the
// far end, then answers and stores a fresh key at the ring write slot.
// ----------------------------------------------------------------------------
module rkf_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [rkf_pkg::KEY_W-1:0] s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [7:0]                m_axis_tdata_o,
  output logic [rkf_pkg::KEY_W-1:0] key_o,
  output rkf_pkg::wr_t              wr_o,
  output rkf_pkg::tok_t             tok_o,
  input  rkf_pkg::tok_t             tok_i
);

  rkf_pkg::state_e                state_d, state_q;
  logic                           launch_d, launch_q;
  logic [rkf_pkg::KEY_W-1:0]      key_q;
  logic                           hit_d, hit_q;
  logic [rkf_pkg::SLOT_W-1:0]     slot_d, slot_q;
  logic [rkf_pkg::CNT_W-1:0]      cnt_d, cnt_q;
  logic                           out_valid_d, out_valid_q;
  logic                           out_fresh_d, out_fresh_q;
  logic                           accept;

  assign s_axis_tready_o = (state_q == rkf_pkg::ST_IDLE);
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;

  always_comb begin
    state_d     = state_q;
    launch_d    = 1'b0;
    hit_d       = hit_q;
    slot_d      = slot_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & ~m_axis_tready_i;
    out_fresh_d = out_fresh_q;
    wr_o.en     = 1'b0;
    wr_o.slot   = slot_q;
    unique case (state_q)
      rkf_pkg::ST_IDLE: begin
        if (accept) begin
          launch_d = 1'b1;
          state_d  = rkf_pkg::ST_SCAN;
        end
      end
      rkf_pkg::ST_SCAN: begin
        if (tok_i.active) begin
          hit_d   = tok_i.hit;
          state_d = rkf_pkg::ST_FINISH;
        end
      end
      rkf_pkg::ST_FINISH: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_fresh_d = ~hit_q;
          state_d     = rkf_pkg::ST_IDLE;
          if (!hit_q) begin
            wr_o.en = 1'b1;
            slot_d  = (slot_q == rkf_pkg::SLOT_W'(rkf_pkg::STORE_DEPTH - 1)) ?
                      '0 : slot_q + 1'b1;
            if (cnt_q != rkf_pkg::CNT_W'(rkf_pkg::STORE_DEPTH)) begin
              cnt_d = cnt_q + 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = rkf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rkf_pkg::ST_IDLE;
      launch_q    <= 1'b0;
      hit_q       <= 1'b0;
      slot_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      launch_q    <= launch_d;
      hit_q       <= hit_d;
      slot_q      <= slot_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= s_axis_tdata_i;
    end
    out_fresh_q <= out_fresh_d;
  end

  assign tok_o.active    = launch_q;
  assign tok_o.hit       = 1'b0;
  assign tok_o.left      = cnt_q;
  assign key_o           = key_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_fresh_q};

endmodule

[sv/replay_key_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replay key filter
// Checks each 256-bit key against a ring store of the last distinct keys and
// answers whether it is fresh; fresh keys are stored, oldest overwritten.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata[255:0] = key_word_0 .. key_word_3
//   m_axis    out        tdata[7:0]   = is_fresh, zero padded
//
// The result is valid once the token has stepped through every store cell,
// one store cell a cycle, however many keys the store holds, and the output
// register has room for it.
// One key is in work at a time; the next is taken once the result is in the
// output register, even while that result waits to be taken.
// A stalled output holds the finished key back before its store write.
// Reset clears control state only; store entries are read only once written.
// ----------------------------------------------------------------------------
module replay_key_filter (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // key_word_0 [63:0], key_word_1 [127:64], key_word_2 [191:128],
  // key_word_3 [255:192]
  input  logic [255:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // is_fresh [0], zero padding [7:1]
  output logic [7:0]   m_axis_tdata_o
);

  logic [rkf_pkg::KEY_W-1:0]       key;
  rkf_pkg::wr_t                    wr;
  rkf_pkg::tok_t                   tok [rkf_pkg::STORE_DEPTH+1];
  logic [rkf_pkg::STORE_DEPTH-1:0] we;

  rkf_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .key_o           (key),
    .wr_o            (wr),
    .tok_o           (tok[0]),
    .tok_i           (tok[rkf_pkg::STORE_DEPTH])
  );

  for (genvar i = 0; i < rkf_pkg::STORE_DEPTH; i++) begin : g_cell
    assign we[i] = wr.en & (wr.slot == rkf_pkg::SLOT_W'(i));

    rkf_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .key_i  (key),
      .we_i   (we[i]),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replay key filter testbench
// Sends 256-bit keys through the input stream and checks every freshness
// answer against a local ring store of the last distinct keys. The stimulus
// covers extreme keys, ring wrap and eviction, replays, near misses, random
// idling on both sides, a long output stall and a stretch without idling.
// ----------------------------------------------------------------------------
module tb;
  import rkf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned MAX_GAP     = 6;
  localparam int unsigned HISTORY_LEN = 200;
  localparam int unsigned LONG_HOLD   = 400;

  typedef struct packed {
    logic [WORD_W-1:0] w3;
    logic [WORD_W-1:0] w2;
    logic [WORD_W-1:0] w1;
    logic [WORD_W-1:0] w0;
  } key_t;

  logic             clk      = 1'b0;
  logic             rst_n    = 1'b0;
  logic             s_valid  = 1'b0;
  logic             s_ready;
  logic [KEY_W-1:0] s_data   = '0;
  logic             m_valid;
  logic             m_ready  = 1'b0;
  logic [7:0]       m_data;

  key_t        stored_keys [STORE_DEPTH];
  int unsigned next_slot;
  int unsigned stored_count;
  bit          fresh_q [$];
  key_t        sent_keys [$];
  bit          expected_fresh;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned rx_hold;
  bit          steady;

  replay_key_filter dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always #5ns clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic bit admit_key(key_t k);
    int unsigned i;
    for (i = 0; i < stored_count; i++) begin
      if (stored_keys[i].w0 == k.w0 && stored_keys[i].w1 == k.w1 &&
          stored_keys[i].w2 == k.w2 && stored_keys[i].w3 == k.w3) begin
        return 1'b0;
      end
    end
    stored_keys[next_slot] = k;
    next_slot = (next_slot + 1) % STORE_DEPTH;
    if (stored_count < STORE_DEPTH) begin
      stored_count++;
    end
    return 1'b1;
  endfunction

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic key_t random_key();
    key_t k;
    k.w0 = random_word();
    k.w1 = random_word();
    k.w2 = random_word();
    k.w3 = random_word();
    return k;
  endfunction

  // Mostly replays of recent keys and near misses of them, so that the store
  // keeps hitting, wrapping and evicting; the rest is fresh random content.
  function automatic key_t mixed_key();
    key_t        k;
    int unsigned pick;
    int unsigned depth;
    pick = $urandom_range(0, 99);
    if (pick < 40 || sent_keys.size() == 0) begin
      return random_key();
    end
    depth = (sent_keys.size() > 100) ? 99 : sent_keys.size() - 1;
    k = sent_keys[sent_keys.size() - 1 - $urandom_range(0, depth)];
    if (pick >= 80) begin
      k[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
    end
    return k;
  endfunction

  task automatic send_key(key_t k);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= k;
    do @(posedge clk); while (!s_ready);
    fresh_q.push_back(admit_key(k));
    sent_keys.push_back(k);
    if (sent_keys.size() > HISTORY_LEN) begin
      void'(sent_keys.pop_front());
    end
  endtask

  task automatic wait_results();
    @(negedge clk);
    s_valid <= 1'b0;
    while (fresh_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    key_t        k;
    int unsigned w;
    send_key('0);
    send_key('0);
    send_key('1);
    send_key('1);
    for (w = 0; w < 4; w++) begin
      k = '0;
      k[w * WORD_W + WORD_W - 1] = 1'b1;
      send_key(k);
      k = '0;
      k[w * WORD_W] = 1'b1;
      send_key(k);
    end
    send_key('0);
  endtask

  task automatic test_ring_eviction();
    key_t batch [$];
    key_t k;
    repeat (STORE_DEPTH + 6) begin
      k = random_key();
      batch.push_back(k);
      send_key(k);
    end
    send_key(batch[STORE_DEPTH + 5]);
    send_key(batch[6]);
    send_key(batch[0]);
    send_key(batch[6]);
  endtask

  task automatic test_random_mix(int unsigned count);
    repeat (count) send_key(mixed_key());
  endtask

  task automatic test_backpressure();
    wait_results();
    rx_hold = LONG_HOLD;
    repeat (10) send_key(mixed_key());
    wait_results();
  endtask

  task automatic test_steady_flow();
    steady = 1'b1;
    repeat (60) send_key(mixed_key());
    steady = 1'b0;
  endtask

  initial begin : result_sink
    int unsigned stall;
    @(posedge rst_n);
    forever begin
      stall = steady ? 0 : $urandom_range(0, MAX_GAP);
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end
      @(negedge clk);
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_ready <= 1'b1;
      do @(posedge clk); while (!m_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) begin
      if (fresh_q.size() == 0) begin
        $error("unexpected result transaction: tdata %0h", m_data);
        fail_count++;
      end else begin
        expected_fresh = fresh_q.pop_front();
        if (m_data[0] !== expected_fresh) begin
          $error("is_fresh: expected %0b, actual %0b", expected_fresh, m_data[0]);
          fail_count++;
        end
        if (m_data[7:1] !== '0) begin
          $error("padding: expected 0, actual %0h", m_data[7:1]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_ring_eviction();
    test_random_mix(900);
    test_backpressure();
    test_steady_flow();
    test_random_mix(900);
    @(negedge clk);
    s_valid <= 1'b0;
    wait_results();
    repeat (STORE_DEPTH + 8) @(posedge clk);
    if (fresh_q.size() != 0) begin
      $error("%0d expected results never arrived", fresh_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
